@@ rtl/oth_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oth_pkg
// shared constants, types and tables of the orbit tangent heading core
// ----------------------------------------------------------------------------
package oth_pkg;

	localparam int unsigned RADIUS_W     = 15;
	localparam int unsigned ROOT_W       = 31;
	localparam int unsigned RQ_W         = 62;
	localparam int unsigned CNT_W        = 7;
	localparam int unsigned SEARCH_STEPS = 7;

	localparam logic [RADIUS_W-1:0] RADIUS_RESET = 15'd2560;
	localparam logic [8:0]  DEG_FULL    = 9'd360;
	localparam logic [8:0]  DEG_HALF    = 9'd180;
	localparam logic [8:0]  DEG_QUARTER = 9'd90;
	localparam logic [7:0]  ANG_MID     = 8'd45;
	localparam logic [7:0]  ANG_MAX     = 8'd89;
	localparam logic [7:0]  ANG_RIGHT   = 8'd90;
	localparam logic [16:0] ONE_Q16     = 17'd65536;

	localparam logic [1:0] QD_0 = 2'd0;
	localparam logic [1:0] QD_1 = 2'd1;
	localparam logic [1:0] QD_2 = 2'd2;
	localparam logic [1:0] QD_3 = 2'd3;

	typedef struct packed {
		logic               fb;
		logic [8:0]         fbhead;
		logic               right;
		logic signed [15:0] p;
		logic signed [15:0] q;
		logic signed [31:0] pq;
		logic signed [31:0] d;
	} oth_side_t;

	typedef struct packed {
		logic [RQ_W-1:0]   rem;
		logic [ROOT_W-1:0] root;
		oth_side_t         side;
	} oth_sq_t;

	typedef struct packed {
		logic             fb;
		logic [8:0]       fbhead;
		logic [1:0]       qd;
		logic [31:0]      a;
		logic [31:0]      b;
		logic [CNT_W-1:0] cnt;
	} oth_ang_t;

	typedef struct packed {
		logic [8:0] move_heading;
		logic       no_tangent;
	} oth_res_t;

	typedef struct packed {
		logic [16:0] ca;
		logic [16:0] cb;
	} oth_coef_t;

	// tan(k deg) in q1.16, tan(45) exactly one
	function automatic logic [16:0] oth_tan(input logic [5:0] k);
		logic [16:0] t;
		case (k)
			6'd0:  t = 17'd0;
			6'd1:  t = 17'd1144;
			6'd2:  t = 17'd2289;
			6'd3:  t = 17'd3435;
			6'd4:  t = 17'd4583;
			6'd5:  t = 17'd5734;
			6'd6:  t = 17'd6888;
			6'd7:  t = 17'd8047;
			6'd8:  t = 17'd9210;
			6'd9:  t = 17'd10380;
			6'd10: t = 17'd11556;
			6'd11: t = 17'd12739;
			6'd12: t = 17'd13930;
			6'd13: t = 17'd15130;
			6'd14: t = 17'd16340;
			6'd15: t = 17'd17560;
			6'd16: t = 17'd18792;
			6'd17: t = 17'd20036;
			6'd18: t = 17'd21294;
			6'd19: t = 17'd22566;
			6'd20: t = 17'd23853;
			6'd21: t = 17'd25157;
			6'd22: t = 17'd26478;
			6'd23: t = 17'd27818;
			6'd24: t = 17'd29179;
			6'd25: t = 17'd30560;
			6'd26: t = 17'd31964;
			6'd27: t = 17'd33392;
			6'd28: t = 17'd34846;
			6'd29: t = 17'd36327;
			6'd30: t = 17'd37837;
			6'd31: t = 17'd39378;
			6'd32: t = 17'd40951;
			6'd33: t = 17'd42560;
			6'd34: t = 17'd44205;
			6'd35: t = 17'd45889;
			6'd36: t = 17'd47615;
			6'd37: t = 17'd49385;
			6'd38: t = 17'd51202;
			6'd39: t = 17'd53070;
			6'd40: t = 17'd54991;
			6'd41: t = 17'd56970;
			6'd42: t = 17'd59009;
			6'd43: t = 17'd61113;
			6'd44: t = 17'd63287;
			default: t = ONE_Q16;
		endcase
		return t;
	endfunction

	// threshold for angle k: b*cb >= a*ca
	function automatic oth_coef_t oth_coef(input logic [7:0] k);
		oth_coef_t c;
		if (k <= ANG_MID) begin
			c.ca = oth_tan(k[5:0]);
			c.cb = ONE_Q16;
		end else if (k <= ANG_MAX) begin
			c.ca = ONE_Q16;
			c.cb = oth_tan(6'(ANG_RIGHT - k));
		end else begin
			c.ca = ONE_Q16;
			c.cb = ONE_Q16;
		end
		return c;
	endfunction

endpackage

@@ rtl/oth_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oth_if
// valid/ready channels of the orbit tangent heading core
// ----------------------------------------------------------------------------
interface oth_in_if;
	logic               valid;
	logic               ready;
	logic [8:0]         ball_bearing;
	logic signed [15:0] ball_x;
	logic signed [15:0] ball_y;

	modport source(output valid, ball_bearing, ball_x, ball_y, input ready);
	modport sink(input valid, ball_bearing, ball_x, ball_y, output ready);
endinterface

interface oth_out_if;
	logic       valid;
	logic       ready;
	logic [8:0] move_heading;
	logic       no_tangent;

	modport source(output valid, move_heading, no_tangent, input ready);
	modport sink(input valid, move_heading, no_tangent, output ready);
endinterface

@@ rtl/oth_sqrt_stage.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oth_sqrt_stage
// one result bit of the pipelined integer square root
// ----------------------------------------------------------------------------
module oth_sqrt_stage
	import oth_pkg::*;
#(
	parameter int unsigned BIT = 0
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    en,
	input  logic    in_valid,
	input  oth_sq_t in_data,
	output logic    out_valid,
	output oth_sq_t out_data
);

	logic [RQ_W-1:0] trial;
	logic            take;
	oth_sq_t         nxt;

	always_comb begin
		trial = (RQ_W'(in_data.root) << (BIT + 1)) + (RQ_W'(1) << (2 * BIT));
		take  = in_data.rem >= trial;
		nxt   = in_data;
		if (take) begin
			nxt.rem  = in_data.rem - trial;
			nxt.root = in_data.root | (ROOT_W'(1) << BIT);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_data <= nxt;
		end
	end

endmodule

@@ rtl/oth_angle_stage.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oth_angle_stage
// one step of the binary search for the whole-degree angle
// ----------------------------------------------------------------------------
module oth_angle_stage
	import oth_pkg::*;
#(
	parameter int unsigned STEP = 1
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     en,
	input  logic     in_valid,
	input  oth_ang_t in_data,
	output logic     out_valid,
	output oth_ang_t out_data
);

	logic [7:0]  k;
	oth_coef_t   coef;
	logic [48:0] lhs;
	logic [48:0] rhs;
	oth_ang_t    nxt;

	always_comb begin
		k    = {1'b0, in_data.cnt} + 8'(STEP);
		coef = oth_coef(k);
		lhs  = {17'b0, in_data.b} * {32'b0, coef.cb};
		rhs  = {17'b0, in_data.a} * {32'b0, coef.ca};
		nxt  = in_data;
		if ((k <= ANG_MAX) && (lhs >= rhs)) begin
			nxt.cnt = k[CNT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_data <= nxt;
		end
	end

endmodule

@@ rtl/oth_out_skid.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oth_out_skid
// output register with skid slot, holds the pipeline while full
// ----------------------------------------------------------------------------
module oth_out_skid
	import oth_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      f_valid,
	input  oth_res_t  f_data,
	output logic      en,
	oth_out_if.source res_out
);

	logic     ov_q;
	logic     sv_q;
	oth_res_t od_q;
	oth_res_t sd_q;
	logic     free;

	assign en   = !sv_q;
	assign free = !ov_q || res_out.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
			sv_q <= 1'b0;
		end else if (free) begin
			if (sv_q) begin
				ov_q <= 1'b1;
				sv_q <= 1'b0;
			end else begin
				ov_q <= f_valid;
			end
		end else if (f_valid && !sv_q) begin
			sv_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (free) begin
			od_q <= sv_q ? sd_q : f_data;
		end else if (!sv_q) begin
			sd_q <= f_data;
		end
	end

	assign res_out.valid        = ov_q;
	assign res_out.move_heading = od_q.move_heading;
	assign res_out.no_tangent   = od_q.no_tangent;

endmodule

@@ rtl/orbit_tangent_heading_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orbit_tangent_heading_core
// heading toward the tangent of the orbit circle around the robot
//
// ball_in carries one query per transaction: bearing and q8.8 ball position.
// heading_out carries one result per query, in order: heading and a flag
// that marks the fallback to the opposite bearing.
// cfg_wr_en/cfg_wr_data write the orbit radius; write it only while idle.
// pipeline: 4 setup stages, 31 square root stages, 4 tangent stages, 7 search
// stages, then the output register. throughput: one transaction per cycle
// while ball_in.ready is high.
// reset clears all valid bits and loads the default radius of 10.0.
// a stalled receiver holds the result in the output register; one more
// result goes to a skid slot, then ball_in.ready drops and the whole
// pipeline holds until the receiver takes the result.
// ----------------------------------------------------------------------------
module orbit_tangent_heading_core
	import oth_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [RADIUS_W-1:0] cfg_wr_data,
	oth_in_if.sink              ball_in,
	oth_out_if.source           heading_out
);

	logic                en;
	logic [RADIUS_W-1:0] radius_q;

	// radius register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RADIUS_RESET;
		end else if (cfg_wr_en) begin
			radius_q <= cfg_wr_data;
		end
	end

	assign ball_in.ready = en;

	// s1: bearing reduction
	logic [8:0] bmod;
	logic [9:0] bsum;
	logic [8:0] fbh;

	always_comb begin
		bmod = (ball_in.ball_bearing >= DEG_FULL) ? ball_in.ball_bearing - DEG_FULL
			: ball_in.ball_bearing;
		bsum = {1'b0, bmod} + {1'b0, DEG_HALF};
		fbh  = (bsum >= {1'b0, DEG_FULL}) ? 9'(bsum - {1'b0, DEG_FULL}) : bsum[8:0];
	end

	logic                v_s1;
	logic [8:0]          fbh_s1;
	logic                right_s1;
	logic signed [15:0]  p_s1;
	logic signed [15:0]  q_s1;
	logic [RADIUS_W-1:0] r_s1;

	// s2: products
	logic                v_s2;
	logic [8:0]          fbh_s2;
	logic                right_s2;
	logic signed [15:0]  p_s2;
	logic signed [15:0]  q_s2;
	logic signed [31:0]  p2_s2;
	logic signed [31:0]  q2_s2;
	logic signed [31:0]  pq_s2;
	logic [29:0]         r2_s2;

	// s3: discriminant and denominator
	logic                v_s3;
	logic [8:0]          fbh_s3;
	logic                right_s3;
	logic signed [15:0]  p_s3;
	logic signed [15:0]  q_s3;
	logic signed [31:0]  pq_s3;
	logic [29:0]         r2_s3;
	logic signed [32:0]  qq_s3;
	logic signed [31:0]  d_s3;

	// s4: radicand
	logic                v_s4;
	logic [RQ_W-1:0]     rq_s4;
	oth_side_t           side_s4;

	logic signed [32:0] qq_c;
	logic signed [31:0] d_c;
	logic [31:0]        qqu;

	always_comb begin
		qq_c = 33'(p2_s2) + 33'(q2_s2) - $signed({3'b0, r2_s2});
		d_c  = $signed({2'b0, r2_s2}) - p2_s2;
		qqu  = qq_s3[32] ? 32'd0 : qq_s3[31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= ball_in.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fbh_s1   <= fbh;
			right_s1 <= bmod > DEG_HALF;
			p_s1     <= ball_in.ball_x;
			q_s1     <= ball_in.ball_y;
			r_s1     <= radius_q;

			fbh_s2   <= fbh_s1;
			right_s2 <= right_s1;
			p_s2     <= p_s1;
			q_s2     <= q_s1;
			p2_s2    <= p_s1 * p_s1;
			q2_s2    <= q_s1 * q_s1;
			pq_s2    <= p_s1 * q_s1;
			r2_s2    <= 30'(r_s1 * r_s1);

			fbh_s3   <= fbh_s2;
			right_s3 <= right_s2;
			p_s3     <= p_s2;
			q_s3     <= q_s2;
			pq_s3    <= pq_s2;
			r2_s3    <= r2_s2;
			qq_s3    <= qq_c;
			d_s3     <= d_c;

			rq_s4          <= RQ_W'(r2_s3) * RQ_W'(qqu);
			side_s4.fb     <= qq_s3[32] || (d_s3 == 32'sd0);
			side_s4.fbhead <= fbh_s3;
			side_s4.right  <= right_s3;
			side_s4.p      <= p_s3;
			side_s4.q      <= q_s3;
			side_s4.pq     <= pq_s3;
			side_s4.d      <= d_s3;
		end
	end

	// square root, one bit per stage
	logic    sq_v [ROOT_W+1];
	oth_sq_t sq_d [ROOT_W+1];

	assign sq_v[0] = v_s4;
	assign sq_d[0] = '{rem: rq_s4, root: '0, side: side_s4};

	for (genvar i = 0; i < ROOT_W; i++) begin : g_sqrt
		oth_sqrt_stage #(
			.BIT(ROOT_W - 1 - i)
		) u_stage (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.in_valid (sq_v[i]),
			.in_data  (sq_d[i]),
			.out_valid(sq_v[i+1]),
			.out_data (sq_d[i+1])
		);
	end

	// s5: numerator
	logic               v_s5;
	oth_side_t          side_s5;
	logic signed [32:0] n_s5;

	// s6: side products
	logic               v_s6;
	oth_side_t          side_s6;
	logic signed [32:0] n_s6;
	logic signed [47:0] pd_s6;
	logic signed [48:0] qn_s6;

	// s7: oriented vector
	logic               v_s7;
	logic               fb_s7;
	logic [8:0]         fbh_s7;
	logic signed [32:0] x_s7;
	logic signed [32:0] y_s7;

	// s8: first quadrant form
	logic               v_s8;
	oth_ang_t           ang_s8;

	oth_sq_t            sq_last;
	logic signed [32:0] s_ext;
	logic signed [32:0] pq_ext;
	logic signed [32:0] n_c;
	logic signed [49:0] side_sum;
	logic signed [32:0] d_ext;
	logic signed [32:0] x_c;
	logic signed [32:0] y_c;
	oth_ang_t           ang_c;

	always_comb begin
		sq_last = sq_d[ROOT_W];
		s_ext   = $signed({2'b0, sq_last.root});
		pq_ext  = 33'(sq_last.side.pq);
		n_c     = sq_last.side.right ? s_ext - pq_ext : -pq_ext - s_ext;

		side_sum = 50'(pd_s6) + 50'(qn_s6);
		d_ext    = 33'(side_s6.d);
		if (side_sum > 50'sd0) begin
			x_c = d_ext;
			y_c = n_s6;
		end else if (side_sum < 50'sd0) begin
			x_c = -d_ext;
			y_c = -n_s6;
		end else begin
			x_c = '0;
			y_c = '0;
		end

		ang_c.fb     = fb_s7;
		ang_c.fbhead = fbh_s7;
		ang_c.cnt    = '0;
		if (x_s7 > 33'sd0 && y_s7 >= 33'sd0) begin
			ang_c.qd = QD_0;
			ang_c.a  = 32'(x_s7);
			ang_c.b  = 32'(y_s7);
		end else if (x_s7 <= 33'sd0 && y_s7 > 33'sd0) begin
			ang_c.qd = QD_1;
			ang_c.a  = 32'(y_s7);
			ang_c.b  = 32'(-x_s7);
		end else if (x_s7 < 33'sd0 && y_s7 <= 33'sd0) begin
			ang_c.qd = QD_2;
			ang_c.a  = 32'(-x_s7);
			ang_c.b  = 32'(-y_s7);
		end else if (x_s7 >= 33'sd0 && y_s7 < 33'sd0) begin
			ang_c.qd = QD_3;
			ang_c.a  = 32'(-y_s7);
			ang_c.b  = 32'(x_s7);
		end else begin
			// zero vector reads as angle zero
			ang_c.qd = QD_0;
			ang_c.a  = 32'd1;
			ang_c.b  = 32'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s5 <= sq_v[ROOT_W];
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s5 <= sq_last.side;
			n_s5    <= n_c;

			side_s6 <= side_s5;
			n_s6    <= n_s5;
			pd_s6   <= side_s5.p * side_s5.d;
			qn_s6   <= side_s5.q * n_s5;

			fb_s7   <= side_s6.fb;
			fbh_s7  <= side_s6.fbhead;
			x_s7    <= x_c;
			y_s7    <= y_c;

			ang_s8  <= ang_c;
		end
	end

	// angle search, one bit of the degree count per stage
	logic     ang_v [SEARCH_STEPS+1];
	oth_ang_t ang_d [SEARCH_STEPS+1];

	assign ang_v[0] = v_s8;
	assign ang_d[0] = ang_s8;

	for (genvar i = 0; i < SEARCH_STEPS; i++) begin : g_search
		oth_angle_stage #(
			.STEP(1 << (SEARCH_STEPS - 1 - i))
		) u_stage (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.in_valid (ang_v[i]),
			.in_data  (ang_d[i]),
			.out_valid(ang_v[i+1]),
			.out_data (ang_d[i+1])
		);
	end

	// heading = angle + 270 mod 360, quadrant index shifted back by one
	oth_ang_t   ang_last;
	logic [1:0] qd_rot;
	logic [8:0] heading;
	oth_res_t   res_c;

	always_comb begin
		ang_last           = ang_d[SEARCH_STEPS];
		qd_rot             = ang_last.qd - QD_1;
		heading            = 9'(9'(qd_rot) * DEG_QUARTER) + 9'(ang_last.cnt);
		res_c.move_heading = ang_last.fb ? ang_last.fbhead : heading;
		res_c.no_tangent   = ang_last.fb;
	end

	oth_out_skid u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.f_valid(ang_v[SEARCH_STEPS]),
		.f_data (res_c),
		.en     (en),
		.res_out(heading_out)
	);

endmodule
